### hw/rtl/pfb2pfa_pkg.sv
// Shared types, codes and helpers for the PFB to PFA converter.
// Used by every module of the converter; depends on nothing.
`timescale 1ns / 1ps

package pfb2pfa_pkg;

   // Width of the kept segment length.
   localparam int LEN_BITS = 32;

   // Depth of the queue between the parser and the expander.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] SEG_MARK = 8'd128;
   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_LF = 8'd10;
   localparam logic [7:0] BPL_RESET = 8'd30;

   localparam logic [7:0] SEG_ASCII = 8'd1;
   localparam logic [7:0] SEG_BINARY = 8'd2;
   localparam logic [7:0] SEG_EOF = 8'd3;

   // Result kinds.
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_EOF = 2'd1;
   localparam logic [1:0] KIND_BAD_MARKER = 2'd2;
   localparam logic [1:0] KIND_BAD_TYPE = 2'd3;

   // One unit of work for the expander: either a single result, or a
   // binary byte that becomes two hex digits plus up to two line feeds.
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       is_hex;
      logic       nl_line;
      logic       nl_end;
   } desc_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'b0000, nib};
      if (nib < 4'd10) begin
         hex_char = 8'h30 + wide;
      end else begin
         hex_char = 8'h57 + wide;
      end
   endfunction

endpackage

### hw/rtl/pfb2pfa_queue.sv
// Small register queue of work descriptors between parser and expander.
// Depends on pfb2pfa_pkg for the descriptor type and depth.
`timescale 1ns / 1ps

module pfb2pfa_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pfb2pfa_pkg::desc_type  push_desc,
   input  logic                   pop,
   output logic                   full,
   output logic                   empty,
   output pfb2pfa_pkg::desc_type  head
);

   pfb2pfa_pkg::desc_type entry_ff [pfb2pfa_pkg::QUEUE_DEPTH];
   logic [pfb2pfa_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pfb2pfa_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pfb2pfa_pkg::QPTR_BITS:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign full  = (count_ff == (pfb2pfa_pkg::QPTR_BITS+1)'(pfb2pfa_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

### hw/rtl/pfb2pfa_front.sv
// Segment parser: accepts raw PFB bytes and turns each byte that gives output into a work descriptor.
// Depends on pfb2pfa_pkg for codes, widths and the descriptor type.
`timescale 1ns / 1ps

module pfb2pfa_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             in_byte,
   input  logic [7:0]             bytes_per_line,
   output logic                   desc_valid,
   output pfb2pfa_pkg::desc_type  desc
);

   localparam logic [2:0] PH_MARKER  = 3'd0;
   localparam logic [2:0] PH_TYPE    = 3'd1;
   localparam logic [2:0] PH_LENGTH  = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_DONE    = 3'd4;
   localparam logic [2:0] PH_HALT    = 3'd5;

   localparam int LB = pfb2pfa_pkg::LEN_BITS;

   logic [2:0]    phase_ff, phase_in;
   logic [1:0]    seg_type_ff, seg_type_in;
   logic [1:0]    len_idx_ff, len_idx_in;
   logic [LB-1:0] remain_ff, remain_in;
   logic [7:0]    column_ff, column_in;

   logic [31:0]   merged;
   logic [LB-1:0] merged_len;
   logic [LB-1:0] remain_dec;
   logic [7:0]    column_next;

   always_comb begin
      merged      = 32'(remain_ff) | (32'(in_byte) << {len_idx_ff, 3'b000});
      merged_len  = merged[LB-1:0];
      remain_dec  = remain_ff - {{(LB-1){1'b0}}, 1'b1};
      column_next = column_ff + 8'd1;

      phase_in    = phase_ff;
      seg_type_in = seg_type_ff;
      len_idx_in  = len_idx_ff;
      remain_in   = remain_ff;
      column_in   = column_ff;
      desc_valid  = 1'b0;
      desc        = '0;

      case (phase_ff)
         PH_MARKER: begin
            if (in_byte != pfb2pfa_pkg::SEG_MARK) begin
               desc_valid = 1'b1;
               desc.kind  = pfb2pfa_pkg::KIND_BAD_MARKER;
               phase_in   = PH_HALT;
            end else begin
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            if (in_byte == pfb2pfa_pkg::SEG_ASCII || in_byte == pfb2pfa_pkg::SEG_BINARY) begin
               seg_type_in = in_byte[1:0];
               len_idx_in  = '0;
               remain_in   = '0;
               column_in   = '0;
               phase_in    = PH_LENGTH;
            end else if (in_byte == pfb2pfa_pkg::SEG_EOF) begin
               seg_type_in = in_byte[1:0];
               desc_valid  = 1'b1;
               desc.kind   = pfb2pfa_pkg::KIND_EOF;
               phase_in    = PH_DONE;
            end else begin
               desc_valid = 1'b1;
               desc.kind  = pfb2pfa_pkg::KIND_BAD_TYPE;
               phase_in   = PH_HALT;
            end
         end
         PH_LENGTH: begin
            remain_in = merged_len;
            if (len_idx_ff == 2'd3) begin
               len_idx_in = '0;
               if (merged_len != '0) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  // An empty binary segment still closes its record with a newline.
                  if (seg_type_ff == pfb2pfa_pkg::SEG_BINARY[1:0]) begin
                     desc_valid = 1'b1;
                     desc.kind  = pfb2pfa_pkg::KIND_CHAR;
                     desc.data  = pfb2pfa_pkg::CH_LF;
                  end
                  phase_in = PH_MARKER;
               end
            end else begin
               len_idx_in = len_idx_ff + 2'd1;
            end
         end
         PH_PAYLOAD: begin
            desc_valid = 1'b1;
            desc.kind  = pfb2pfa_pkg::KIND_CHAR;
            if (seg_type_ff == pfb2pfa_pkg::SEG_ASCII[1:0]) begin
               desc.data = (in_byte == pfb2pfa_pkg::CH_CR) ? pfb2pfa_pkg::CH_LF : in_byte;
            end else begin
               desc.data    = in_byte;
               desc.is_hex  = 1'b1;
               desc.nl_line = (column_next == bytes_per_line);
               column_in    = desc.nl_line ? 8'd0 : column_next;
            end
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               desc.nl_end = (seg_type_ff == pfb2pfa_pkg::SEG_BINARY[1:0]);
               phase_in    = PH_MARKER;
            end
         end
         default: begin
         end
      endcase

      if (!accept) begin
         desc_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MARKER;
         seg_type_ff <= '0;
         len_idx_ff  <= '0;
         remain_ff   <= '0;
         column_ff   <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         seg_type_ff <= seg_type_in;
         len_idx_ff  <= len_idx_in;
         remain_ff   <= remain_in;
         column_ff   <= column_in;
      end
   end

endmodule

### hw/rtl/pfb2pfa_back.sv
// Expander: turns queued descriptors into one result per cycle in an output register while the receiver pops.
// Depends on pfb2pfa_pkg for the descriptor type and the hex digit function.
`timescale 1ns / 1ps

module pfb2pfa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  pfb2pfa_pkg::desc_type  head,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [7:0]             rsp_out_char,
   output logic [1:0]             rsp_kind,
   output logic                   rsp_last
);

   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic [1:0] kind_ff;
   logic       last_ff;

   logic [1:0] last_step;
   logic       is_last;
   logic       advance;

   always_comb begin
      if (head.is_hex) begin
         last_step = 2'd1 + {1'b0, head.nl_line} + {1'b0, head.nl_end};
      end else begin
         last_step = 2'd0;
      end
      is_last = (step_ff == last_step);

      if (!head.is_hex) begin
         char_in = head.data;
      end else begin
         case (step_ff)
            2'd0:    char_in = pfb2pfa_pkg::hex_char(head.data[7:4]);
            2'd1:    char_in = pfb2pfa_pkg::hex_char(head.data[3:0]);
            default: char_in = pfb2pfa_pkg::CH_LF;
         endcase
      end

      advance = !q_empty && (!valid_ff || rsp_pop);
      q_pop   = advance && is_last;

      step_in = step_ff;
      if (advance) begin
         step_in = is_last ? 2'd0 : step_ff + 2'd1;
      end

      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         char_ff <= char_in;
         kind_ff <= head.kind;
         last_ff <= is_last;
      end
   end

   assign rsp_empty    = !valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_last     = last_ff;

endmodule

### hw/rtl/pfb_to_pfa_converter_core.sv
// Top level of the PFB to PFA converter: config register, parser, queue, expander.
// Depends on pfb2pfa_pkg, pfb2pfa_front, pfb2pfa_queue and pfb2pfa_back.
`timescale 1ns / 1ps
//
// The block reads a PFB font file one byte per item on the request side
// (req_push / req_full / req_in_byte) and writes the PFA text one character
// per item on the response side (rsp_empty / rsp_pop / rsp_out_char,
// rsp_kind, rsp_last). An input byte yields zero to four response items;
// rsp_last marks the final one belonging to that byte. A non-character kind
// reports end of file, a bad segment marker or a bad segment type.
// The csr_ port writes bytes_per_line, the hex bytes per output line.
//
// The first item caused by an accepted byte passes through the queue and
// then the result register before it reaches the response ports. An ASCII
// byte gives one item, a binary byte two (three or four when it closes a
// line or the segment), and the expander feeds the single result register
// one item per cycle while the receiver pops. A four-entry queue between
// parser and expander lets the parser keep taking bytes as the expander works.
//
// Reset clears the parser to expect a segment marker, empties the queue and
// the result register, and sets bytes_per_line to 30. When the receiver
// stops popping, the result holds, the queue fills and req_full rises.
// After an error the block takes bytes but produces nothing until reset.

module pfb_to_pfa_converter_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_kind,
   output logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic [7:0] bpl_ff, bpl_in;

   logic                  accept;
   logic                  desc_valid;
   pfb2pfa_pkg::desc_type desc;
   pfb2pfa_pkg::desc_type head;
   logic                  q_full, q_empty, q_pop;

   // Every accepted byte needs a free queue slot, even one that makes no
   // result; this keeps the accept decision independent of the parser state.
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   assign bpl_in = csr_write_enable ? csr_write_data : bpl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpl_ff <= pfb2pfa_pkg::BPL_RESET;
      end else begin
         bpl_ff <= bpl_in;
      end
   end

   pfb2pfa_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .in_byte        (req_in_byte),
      .bytes_per_line (bpl_ff),
      .desc_valid     (desc_valid),
      .desc           (desc)
   );

   pfb2pfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_valid),
      .push_desc (desc),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head)
   );

   pfb2pfa_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .head         (head),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_char (rsp_out_char),
      .rsp_kind     (rsp_kind),
      .rsp_last     (rsp_last)
   );

endmodule

### hw/rtl/pfb2pfa_checker.sv
// Port-level checks for the PFB to PFA converter, bound to the top level.
// Depends on pfb2pfa_pkg for the result kind codes.
`timescale 1ns / 1ps

module pfb2pfa_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_char,
   input logic [1:0] rsp_kind,
   input logic       rsp_last
);

   // Reset leaves no stale result and room for input.
   a_reset_empty: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("result or full flag present after reset");

   // A status result is always alone for its byte and carries a zero character.
   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != pfb2pfa_pkg::KIND_CHAR) |-> (rsp_last && rsp_out_char == 8'd0))
      else $error("status result not final or with nonzero character");

   // A result cannot appear after reset while no byte has been pushed.
   a_no_early_result: assert property (@(posedge clock)
      (reset ##1 !req_push) |=> rsp_empty)
      else $error("result appeared without an accepted byte");

   // A waiting result holds while the receiver stalls.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_char)
                                    && $stable(rsp_kind) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind pfb_to_pfa_converter_core pfb2pfa_checker u_pfb2pfa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_push     (req_push),
   .req_full     (req_full),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_out_char (rsp_out_char),
   .rsp_kind     (rsp_kind),
   .rsp_last     (rsp_last)
);

### bench/pfb_to_pfa_checker.sv
// Checker for the PFB to PFA converter: watches the byte, character and register ports,
// predicts every output character and compares it with what the block produces.
// Depends on pfb2pfa_pkg for widths, segment codes and result kinds.
`timescale 1ns / 1ps

module pfb_to_pfa_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_out_char,
   input  logic [1:0] rsp_kind,
   input  logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   output int         pending_results,
   output int         failures
);

   typedef enum logic [2:0] {
      WAIT_MARKER,
      WAIT_TYPE,
      READ_LENGTH,
      READ_PAYLOAD,
      FILE_DONE,
      HALTED
   } parse_state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic [1:0] kind;
      logic       last;
   } pfa_char_type;

   localparam logic [31:0] LEN_MASK = 32'hFFFF_FFFF >> (32 - pfb2pfa_pkg::LEN_BITS);

   pfa_char_type    expected_chars[$];
   parse_state_type state;
   logic [7:0]      seg_type;
   logic [1:0]      len_byte;
   logic [31:0]     remaining;
   logic [7:0]      column;
   logic [7:0]      line_bytes;
   int              mismatches = 0;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return {4'h3, nib};
      end
      return {4'h6, nib - 4'd9};
   endfunction

   function automatic pfa_char_type make_char(input logic [7:0] ch, input logic [1:0] kind);
      pfa_char_type c;
      c.ch = ch;
      c.kind = kind;
      c.last = 1'b0;
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Walks the parser one byte and queues the characters it gives.
   task automatic convert_byte(input logic [7:0] b);
      pfa_char_type outs[4];
      int           n;
      n = 0;
      case (state)
         WAIT_MARKER: begin
            if (b != pfb2pfa_pkg::SEG_MARK) begin
               outs[n] = make_char(8'd0, pfb2pfa_pkg::KIND_BAD_MARKER);
               n = n + 1;
               state = HALTED;
            end else begin
               state = WAIT_TYPE;
            end
         end
         WAIT_TYPE: begin
            if (b == pfb2pfa_pkg::SEG_ASCII || b == pfb2pfa_pkg::SEG_BINARY) begin
               seg_type = b;
               len_byte = 2'd0;
               remaining = 32'd0;
               column = 8'd0;
               state = READ_LENGTH;
            end else if (b == pfb2pfa_pkg::SEG_EOF) begin
               seg_type = pfb2pfa_pkg::SEG_EOF;
               outs[n] = make_char(8'd0, pfb2pfa_pkg::KIND_EOF);
               n = n + 1;
               state = FILE_DONE;
            end else begin
               outs[n] = make_char(8'd0, pfb2pfa_pkg::KIND_BAD_TYPE);
               n = n + 1;
               state = HALTED;
            end
         end
         READ_LENGTH: begin
            remaining = (remaining | ({24'd0, b} << (8 * len_byte))) & LEN_MASK;
            if (len_byte == 2'd3) begin
               len_byte = 2'd0;
               if (remaining != 32'd0) begin
                  state = READ_PAYLOAD;
               end else begin
                  if (seg_type == pfb2pfa_pkg::SEG_BINARY) begin
                     outs[n] = make_char(pfb2pfa_pkg::CH_LF, pfb2pfa_pkg::KIND_CHAR);
                     n = n + 1;
                  end
                  state = WAIT_MARKER;
               end
            end else begin
               len_byte = len_byte + 2'd1;
            end
         end
         READ_PAYLOAD: begin
            if (seg_type == pfb2pfa_pkg::SEG_ASCII) begin
               outs[n] = make_char((b == pfb2pfa_pkg::CH_CR) ? pfb2pfa_pkg::CH_LF : b,
                                   pfb2pfa_pkg::KIND_CHAR);
               n = n + 1;
            end else begin
               outs[n] = make_char(hex_digit(b[7:4]), pfb2pfa_pkg::KIND_CHAR);
               n = n + 1;
               outs[n] = make_char(hex_digit(b[3:0]), pfb2pfa_pkg::KIND_CHAR);
               n = n + 1;
               column = column + 8'd1;
               if (column == line_bytes) begin
                  outs[n] = make_char(pfb2pfa_pkg::CH_LF, pfb2pfa_pkg::KIND_CHAR);
                  n = n + 1;
                  column = 8'd0;
               end
            end
            remaining = remaining - 32'd1;
            if (remaining == 32'd0) begin
               if (seg_type == pfb2pfa_pkg::SEG_BINARY) begin
                  outs[n] = make_char(pfb2pfa_pkg::CH_LF, pfb2pfa_pkg::KIND_CHAR);
                  n = n + 1;
               end
               state = WAIT_MARKER;
            end
         end
         default: begin
         end
      endcase
      if (n > 0) begin
         outs[n - 1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         expected_chars.push_back(outs[i]);
      end
   endtask

   always @(posedge clock) begin : watch
      pfa_char_type oldest;
      if (reset) begin
         state = WAIT_MARKER;
         seg_type = 8'd0;
         len_byte = 2'd0;
         remaining = 32'd0;
         column = 8'd0;
         line_bytes = pfb2pfa_pkg::BPL_RESET;
         expected_chars.delete();
      end else begin
         if (csr_write_enable) begin
            line_bytes = csr_write_data;
         end
         if (req_push && !req_full) begin
            convert_byte(req_in_byte);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected item char=%02h kind=%0d last=%0b",
                                         rsp_out_char, rsp_kind, rsp_last));
            end else begin
               oldest = expected_chars.pop_front();
               if (rsp_out_char !== oldest.ch) begin
                  report_mismatch($sformatf("out_char %02h, expected %02h",
                                            rsp_out_char, oldest.ch));
               end
               if (rsp_kind !== oldest.kind) begin
                  report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, oldest.kind));
               end
               if (rsp_last !== oldest.last) begin
                  report_mismatch($sformatf("last %0b, expected %0b", rsp_last, oldest.last));
               end
            end
         end
      end
      pending_results <= expected_chars.size();
      failures <= mismatches;
   end

endmodule

### bench/testbench.sv
// Top of the PFB to PFA converter bench: clock, reset, byte stimulus, pop pacing and verdict.
// Depends on pfb2pfa_pkg, pfb_to_pfa_converter_core and pfb_to_pfa_checker.
`timescale 1ns / 1ps

module testbench;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_in_byte;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_out_char;
   logic [1:0] rsp_kind;
   logic       rsp_last;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   int pending_results;
   int failures;

   // Random gaps on both sides are allowed while this is set; the closing
   // stretch of the run clears it so the block also sees back-to-back traffic.
   bit idling_on = 1'b0;
   int bytes_sent = 0;

   pfb_to_pfa_converter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_in_byte      (req_in_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_char     (rsp_out_char),
      .rsp_kind         (rsp_kind),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   pfb_to_pfa_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_in_byte      (req_in_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_char     (rsp_out_char),
      .rsp_kind         (rsp_kind),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pending_results  (pending_results),
      .failures         (failures)
   );

   // The clock starts low so the first rising edge falls at 4 ns.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Sends one byte, possibly after a short gap, and returns at the edge that
   // accepted it. It is always entered right at a rising edge, so the single
   // nonblocking update of req_push in this step is the one made here.
   task automatic send_byte(input logic [7:0] b);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   // Stops sending and waits until every predicted character has been popped.
   // The checker's count is registered, hence the first wait. A further wait
   // follows before anything else happens.
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
   endtask

   // The line length is only changed while the block has nothing in flight.
   task automatic write_line_bytes(input logic [7:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Segment marker, type and the four little-endian length bytes.
   task automatic send_header(input logic [7:0] seg, input logic [31:0] len);
      send_byte(pfb2pfa_pkg::SEG_MARK);
      send_byte(seg);
      for (int k = 0; k < 4; k++) begin
         send_byte(len[8 * k +: 8]);
      end
   endtask

   // A whole segment with random payload. ASCII payload gets extra carriage
   // returns so the translation is hit often. When change_at is a payload
   // index, the line length is rewritten there, in the middle of the segment.
   task automatic send_segment(input logic [7:0] seg, input int len, input int change_at);
      logic [7:0] b;
      send_header(seg, len);
      for (int k = 0; k < len; k++) begin
         if (k == change_at) begin
            write_line_bytes(8'($urandom_range(1, 16)));
         end
         b = 8'($urandom);
         if (seg == pfb2pfa_pkg::SEG_ASCII && $urandom_range(0, 5) == 0) begin
            b = pfb2pfa_pkg::CH_CR;
         end
         send_byte(b);
      end
   endtask

   // Pop pacing: the receiver stalls in short random bursts while idling is
   // allowed, and otherwise pops every cycle.
   initial begin
      @(posedge clock);
      forever begin
         if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   initial begin
      int         random_start;
      int         seg_len;
      int         change_at;
      logic [7:0] seg;
      logic [7:0] bad;
      reset = 1'b1;
      req_push = 1'b0;
      req_in_byte = 8'd0;
      rsp_pop = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 8'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      idling_on = 1'b1;

      // Directed start. An ASCII segment with a carriage return, a line feed
      // and both byte extremes, then empty ASCII and binary segments: the
      // empty binary one still gives its closing line feed.
      send_header(pfb2pfa_pkg::SEG_ASCII, 32'd4);
      send_byte(pfb2pfa_pkg::CH_CR);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(pfb2pfa_pkg::CH_LF);
      send_header(pfb2pfa_pkg::SEG_ASCII, 32'd0);
      send_header(pfb2pfa_pkg::SEG_BINARY, 32'd0);

      // Binary at the reset line length of 30: one full line and a short one.
      send_segment(pfb2pfa_pkg::SEG_BINARY, 31, -1);

      // Shortest line: every byte closes a line, and the last one also closes
      // the segment, which gives the most characters one byte can cause.
      write_line_bytes(8'd1);
      send_header(pfb2pfa_pkg::SEG_BINARY, 32'd3);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'ha5);

      // Long lines. A length of zero means 256, so no line break may appear
      // in the first 200 bytes. Switching to 255 there still lets the column
      // reach 255 and break. Switching back to zero three bytes into the next
      // line leaves the column past the new value, so it must count on
      // through the wrap instead of breaking at once. The length of 262 also
      // puts a nonzero value in the second length byte.
      write_line_bytes(8'd0);
      send_header(pfb2pfa_pkg::SEG_BINARY, 32'd262);
      for (int k = 0; k < 262; k++) begin
         if (k == 200) begin
            write_line_bytes(8'd255);
         end
         if (k == 258) begin
            write_line_bytes(8'd0);
         end
         send_byte(8'($urandom));
      end

      // Random part, the closing stretch without idling: phases of short
      // well-formed segments, each phase at its own line length, a few empty
      // ones, and now and then a line length change in the middle of a binary
      // segment. Every phase starts by draining the block, which also gives
      // the sender pauses that last until all characters have come out.
      idling_on = 1'b0;
      random_start = bytes_sent;
      while (bytes_sent - random_start < 16) begin
         write_line_bytes(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 3))
                                                       : 8'($urandom_range(1, 24)));
         repeat ($urandom_range(1, 2)) begin
            seg = ($urandom_range(0, 2) == 0) ? pfb2pfa_pkg::SEG_ASCII
                                              : pfb2pfa_pkg::SEG_BINARY;
            seg_len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 12);
            change_at = -1;
            if (seg == pfb2pfa_pkg::SEG_BINARY && seg_len > 4
                && $urandom_range(0, 4) == 0) begin
               change_at = $urandom_range(1, seg_len - 1);
            end
            send_segment(seg, seg_len, change_at);
         end
      end

      // Any of the three ways the file can end leaves the block deaf until
      // reset, so only one of them fits in a run: the end-of-file segment, a
      // wrong marker, or a wrong segment type. The seed picks which. The bytes
      // that follow must give no output at all.
      case ($urandom_range(0, 2))
         0: begin
            send_byte(pfb2pfa_pkg::SEG_MARK);
            send_byte(pfb2pfa_pkg::SEG_EOF);
         end
         1: begin
            bad = 8'($urandom);
            if (bad == pfb2pfa_pkg::SEG_MARK) begin
               bad = 8'h00;
            end
            send_byte(bad);
         end
         default: begin
            bad = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(4, 255));
            send_byte(pfb2pfa_pkg::SEG_MARK);
            send_byte(bad);
         end
      endcase
      send_byte(pfb2pfa_pkg::SEG_MARK);
      send_byte(pfb2pfa_pkg::SEG_BINARY);
      repeat (6) begin
         send_byte(8'($urandom));
      end

      wait_drained();
      if (failures == 0) begin
         $display("PASS pfb_to_pfa_converter_core");
      end else begin
         $display("FAIL pfb_to_pfa_converter_core");
      end
      $finish;
   end

   // Far beyond the slowest correct run, even with every byte fully stalled.
   initial begin
      #2_000_000;
      $display("FAIL pfb_to_pfa_converter_core");
      $finish;
   end

endmodule

### pfb_to_pfa_converter_core.f
hw/rtl/pfb2pfa_pkg.sv
hw/rtl/pfb2pfa_queue.sv
hw/rtl/pfb2pfa_front.sv
hw/rtl/pfb2pfa_back.sv
hw/rtl/pfb_to_pfa_converter_core.sv
hw/rtl/pfb2pfa_checker.sv
bench/pfb_to_pfa_checker.sv
bench/testbench.sv
